### hdl/ffsga_pkg.sv
// Shared types and constants for the first-fit square grid allocator.
package ffsga_pkg;

   localparam logic [1:0] ST_PLACED  = 2'd0;
   localparam logic [1:0] ST_NOFIT   = 2'd1;
   localparam logic [1:0] ST_TERM    = 2'd2;
   localparam logic [1:0] ST_CLEARED = 2'd3;

   localparam logic OP_PLACE = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   localparam logic [1:0] REG_SCALE  = 2'd0;
   localparam logic [1:0] REG_PITCH  = 2'd1;
   localparam logic [1:0] REG_BORDER = 2'd2;

   localparam int REQ_W = 24;
   localparam int RSP_W = 72;

endpackage

### hdl/ffsga_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module ffsga_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

### hdl/first_fit_square_grid_allocator.sv
// Top level of the first-fit square grid allocator.
//
// The req_ channel takes requests: tdata[0] opcode (place or clear),
// tdata[16:1] radius in Q8.8. The rsp_ channel returns one result per
// request: status, corner row and column, pixel x and y, drawn size.
// Registers scale, cell_pitch and border_offset are written over the
// csr_ APB port at byte addresses 0, 4 and 8.
// One request is processed at a time. A place request divides the radius
// by the scale in a bit-serial divider, then scans each start row: side
// rows of the bitmap are read from the RAM one per cycle and OR-ed; the
// free columns are found by a sweep across the columns. Marking reads
// and rewrites each of the side rows in turn, and then the result is
// loaded into the output register.
// A clear request sweeps GRID_ROWS rows, one per cycle. After reset the
// same sweep runs once before the first request is taken. A result waits
// in the output register while the receiver stalls; the next request is
// taken once the output register is empty.
module first_fit_square_grid_allocator
   import ffsga_pkg::*;
#(
   parameter int GRID_ROWS = 32,
   parameter int GRID_COLS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // opcode[0], radius[16:1], zero fill
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // status[1:0], corner_row[9:2], corner_col[17:10], pixel_x[34:18],
   // pixel_y[51:35], draw_size[67:52], zero fill
   output logic [RSP_W-1:0]  rsp_tdata,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int RC = $clog2(GRID_ROWS + 1);
   localparam int CC = $clog2(GRID_COLS + 1);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DIV, S_ROW, S_RD, S_ACC, S_SCAN, S_MARK, S_MWR, S_OUT
   } state_type;

   state_type state_ff, state_in;

   logic [15:0] scale_ff;
   logic [7:0]  pitch_ff;
   logic [9:0]  border_ff;

   logic [15:0] quot_ff, quot_in, rem_ff, rem_in, div_ff;
   logic [4:0]  dcnt_ff, dcnt_in;
   logic [16:0] side_ff, side_in;
   logic [RC-1:0] row_ff, row_in, k_ff, k_in;
   logic [CC-1:0] col_ff, col_in, run_ff, run_in;
   logic [GRID_COLS-1:0] acc_ff, acc_in;
   logic [1:0]  stat_ff, stat_in;
   logic [7:0]  crow_ff, crow_in, ccol_ff, ccol_in;
   logic [16:0] px_ff, px_in, py_ff, py_in;
   logic [15:0] dsz_ff, dsz_in;
   logic        ovld_ff, ovld_in;

   logic                 wr_en;
   logic [RW-1:0]        wr_addr, rd_addr;
   logic [GRID_COLS-1:0] wr_data, rd_data, mark_mask;
   logic [16:0]          rem_sh;
   logic                 csr_wr;

   ffsga_ram #(.WIDTH(GRID_COLS), .DEPTH(GRID_ROWS)) u_map (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   always_comb begin
      case (csr_paddr[3:2])
         REG_SCALE:  csr_prdata = {16'd0, scale_ff};
         REG_PITCH:  csr_prdata = {24'd0, pitch_ff};
         REG_BORDER: csr_prdata = {22'd0, border_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE) && !ovld_ff;
   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = {4'd0, dsz_ff, py_ff, px_ff, ccol_ff, crow_ff, stat_ff};

   // mask of side columns starting at the found column
   always_comb begin
      for (int i = 0; i < GRID_COLS; i++) begin
         mark_mask[i] = (i >= 32'(col_ff)) && (i < 32'(col_ff) + 32'(side_ff));
      end
   end

   assign rem_sh = {rem_ff, quot_ff[15]};

   always_comb begin
      state_in = state_ff;
      quot_in = quot_ff; rem_in = rem_ff; dcnt_in = dcnt_ff; side_in = side_ff;
      row_in = row_ff; k_in = k_ff; col_in = col_ff; run_in = run_ff;
      acc_in = acc_ff;
      stat_in = stat_ff; crow_in = crow_ff; ccol_in = ccol_ff;
      px_in = px_ff; py_in = py_ff; dsz_in = dsz_ff;
      ovld_in = ovld_ff && !rsp_tready;
      wr_en = 1'b0; wr_addr = row_ff[RW-1:0]; wr_data = '0;
      rd_addr = RW'(32'(row_ff) + 32'(k_ff));
      case (state_ff)
         S_INIT: begin
            wr_en = 1'b1;
            row_in = row_ff + 1'b1;
            if (32'(row_ff) == GRID_ROWS - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               stat_in = ST_CLEARED; crow_in = '0; ccol_in = '0;
               px_in = '0; py_in = '0; dsz_in = '0;
               row_in = '0;
               if (req_tdata[0] == OP_CLEAR) begin
                  state_in = S_INIT;
                  ovld_in = 1'b1;
               end else begin
                  quot_in = req_tdata[16:1]; rem_in = '0; dcnt_in = '0;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            quot_in = {quot_ff[14:0], 1'b0};
            if (rem_sh >= {1'b0, div_ff}) begin
               rem_in = 16'(rem_sh - {1'b0, div_ff});
               quot_in[0] = 1'b1;
            end else begin
               rem_in = rem_sh[15:0];
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 5'd15) begin
               side_in = (quot_in == 16'd0) ? 17'd1 : {1'b0, quot_in};
               row_in = '0;
               state_in = S_ROW;
            end
         end
         S_ROW: begin
            // next candidate start row, or no fit
            if (32'(row_ff) + 32'(side_ff) > GRID_ROWS || 32'(side_ff) > GRID_COLS) begin
               stat_in = (side_ff == 17'd1) ? ST_TERM : ST_NOFIT;
               ovld_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               k_in = '0; acc_in = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            k_in = k_ff + 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = acc_ff | rd_data;
            if (32'(k_ff) == 32'(side_ff)) begin
               col_in = '0; run_in = '0;
               state_in = S_SCAN;
            end else begin
               k_in = k_ff + 1'b1;
               rd_addr = RW'(32'(row_ff) + 32'(k_ff));
            end
         end
         S_SCAN: begin
            // find side consecutive free columns
            if (32'(col_ff) == GRID_COLS) begin
               row_in = row_ff + 1'b1;
               state_in = S_ROW;
            end else if (acc_ff[col_ff[CW-1:0]]) begin
               run_in = '0;
               col_in = col_ff + 1'b1;
            end else if (32'(run_ff) + 1 == 32'(side_ff)) begin
               col_in = CC'(32'(col_ff) + 1 - 32'(side_ff));
               k_in = '0;
               state_in = S_MARK;
            end else begin
               run_in = run_ff + 1'b1;
               col_in = col_ff + 1'b1;
            end
         end
         S_MARK: begin
            // read the row to be marked
            state_in = S_MWR;
         end
         S_MWR: begin
            // write the row back with the square's columns set
            wr_en = 1'b1;
            wr_addr = RW'(32'(row_ff) + 32'(k_ff));
            wr_data = rd_data | mark_mask;
            k_in = k_ff + 1'b1;
            if (32'(k_ff) + 1 == 32'(side_ff)) begin
               state_in = S_OUT;
            end else begin
               state_in = S_MARK;
            end
         end
         S_OUT: begin
            stat_in = ST_PLACED;
            crow_in = 8'(row_ff); ccol_in = 8'(col_ff);
            px_in = 17'({7'd0, border_ff} + 17'(col_ff) * 17'(pitch_ff));
            py_in = 17'({7'd0, border_ff} + 17'(row_ff) * 17'(pitch_ff));
            dsz_in = 16'(side_ff * 17'(pitch_ff));
            ovld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         row_ff <= '0;
         ovld_ff <= 1'b0;
         scale_ff <= 16'd256; pitch_ff <= 8'd8; border_ff <= 10'd0;
      end else begin
         state_ff <= state_in;
         row_ff <= row_in;
         ovld_ff <= ovld_in;
         if (csr_wr) begin
            case (csr_paddr[3:2])
               REG_SCALE:  scale_ff <= csr_pwdata[15:0];
               REG_PITCH:  pitch_ff <= csr_pwdata[7:0];
               REG_BORDER: border_ff <= csr_pwdata[9:0];
               default: ;
            endcase
         end
      end
      div_ff <= (scale_ff == 16'd0) ? 16'd1 : scale_ff;
      quot_ff <= quot_in; rem_ff <= rem_in; dcnt_ff <= dcnt_in; side_ff <= side_in;
      k_ff <= k_in; col_ff <= col_in; run_ff <= run_in; acc_ff <= acc_in;
      stat_ff <= stat_in; crow_ff <= crow_in; ccol_ff <= ccol_in;
      px_ff <= px_in; py_ff <= py_in; dsz_ff <= dsz_in;
   end
endmodule
